// ===== rtl/dsdq_pkg.sv =====
package dsdq_pkg;

    localparam int CAPACITY    = 64;
    localparam int QUEUE_DEPTH = 4;

    // Operation codes of the input item
    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_FLUSH = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        K_PUSH,
        K_FLUSH,
        K_CLEAR
    } t_kind;

    typedef struct packed {
        logic [1:0]         op;
        logic [15:0]        texture_id;
        logic [63:0]        pos_xy;
        logic [63:0]        size_wh;
        logic [63:0]        src_rect;
        logic signed [31:0] sort_key;
        logic signed [31:0] rotation;
        logic [31:0]        color_rgba;
    } t_in;

    typedef struct packed {
        logic [15:0]        out_texture_id;
        logic [63:0]        out_pos_xy;
        logic [63:0]        out_size_wh;
        logic [63:0]        out_src_rect;
        logic signed [31:0] out_rotation;
        logic [31:0]        out_color_rgba;
        logic               last;
    } t_out;

    // One stored draw request with its key
    typedef struct packed {
        logic signed [31:0] key;
        logic [15:0]        texture_id;
        logic [63:0]        pos_xy;
        logic [63:0]        size_wh;
        logic [63:0]        src_rect;
        logic signed [31:0] rotation;
        logic [31:0]        color_rgba;
    } t_entry;

    // Classified command handed from front to back
    typedef struct packed {
        t_kind  kind;
        t_entry entry;
    } t_cmd;

endpackage

// ===== rtl/depth_sorted_draw_queue.sv =====
// Depth sorted draw queue: buffers up to CAPACITY sprite draw requests and
// hands them out in ascending signed sort_key order, equal keys in push order.
// Input channel: i_valid / o_stall with payload i_data. op push stores one
// request (dropped when full), op flush emits all stored requests and empties
// the buffer, op clear empties it silently; other op codes are ignored.
// Output channel: o_valid / i_stall with payload o_data; last marks the final
// request of a flush. A flush of an empty buffer emits nothing.
// A front stage classifies transactions into a QUEUE_DEPTH command queue; the
// back end executes one command per cycle while idle, not during a flush. A
// push is written into the insertion chain when taken, so pushes sustain one
// per cycle while no flush runs. A flush emits one request per cycle, pausing
// while the receiver stalls; its command passes the queue and the flush state
// before the output register. Commands behind a flush wait in the queue; the
// input stalls only when that queue is full. Reset empties the buffer and the
// queue. While the receiver stalls, the output register holds.
module depth_sorted_draw_queue #(
    parameter int CAPACITY    = dsdq_pkg::CAPACITY,
    parameter int QUEUE_DEPTH = dsdq_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  dsdq_pkg::t_in   i_data,
    output logic            o_stall,
    output logic            o_valid,
    output dsdq_pkg::t_out  o_data,
    input  logic            i_stall
);

    logic           cmd_valid, cmd_pop;
    dsdq_pkg::t_cmd cmd;

    dsdq_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data      (i_data),
        .o_stall     (o_stall),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_pop       (cmd_pop)
    );

    dsdq_back #(.CAPACITY(CAPACITY)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_pop       (cmd_pop),
        .o_valid     (o_valid),
        .o_data      (o_data),
        .i_stall     (i_stall)
    );

endmodule

// ===== rtl/dsdq_front.sv =====
module dsdq_front #(
    parameter int QUEUE_DEPTH = dsdq_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  dsdq_pkg::t_in   i_data,
    output logic            o_stall,
    output logic            o_cmd_valid,
    output dsdq_pkg::t_cmd  o_cmd,
    input  logic            i_pop
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    dsdq_pkg::t_cmd r_mem [QUEUE_DEPTH];
    logic [AW-1:0]  r_wr, r_rd;
    logic [CW-1:0]  r_fill;
    logic           accept, known, push, pop;
    dsdq_pkg::t_cmd cmd;

    // Classify the incoming transaction; unknown codes are dropped
    always_comb begin
        cmd.entry = '{key: i_data.sort_key, texture_id: i_data.texture_id,
                      pos_xy: i_data.pos_xy, size_wh: i_data.size_wh,
                      src_rect: i_data.src_rect, rotation: i_data.rotation,
                      color_rgba: i_data.color_rgba};
        known = 1'b1;
        unique case (i_data.op)
            dsdq_pkg::OP_PUSH:  cmd.kind = dsdq_pkg::K_PUSH;
            dsdq_pkg::OP_FLUSH: cmd.kind = dsdq_pkg::K_FLUSH;
            dsdq_pkg::OP_CLEAR: cmd.kind = dsdq_pkg::K_CLEAR;
            default: begin
                cmd.kind = dsdq_pkg::K_CLEAR;
                known    = 1'b0;
            end
        endcase
    end

    assign o_stall     = (r_fill == CW'(QUEUE_DEPTH));
    assign accept      = i_valid && !o_stall;
    assign push        = accept && known;
    assign o_cmd_valid = (r_fill != '0);
    assign pop         = i_pop && o_cmd_valid;
    assign o_cmd       = r_mem[r_rd];

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] p);
        return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    // Advance queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (push) r_wr <= f_next(r_wr);
            if (pop)  r_rd <= f_next(r_rd);
            r_fill <= r_fill + CW'(push) - CW'(pop);
        end
    end

    // Store command
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= cmd;
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(QUEUE_DEPTH))
        else $error("queue overfilled");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == '0) |-> !pop)
        else $error("pop from empty queue");
    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_fill == $past(r_fill) + CW'(1)))
        else $error("fill level did not grow");

endmodule

// ===== rtl/dsdq_back.sv =====
module dsdq_back #(
    parameter int CAPACITY = dsdq_pkg::CAPACITY
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  dsdq_pkg::t_cmd  i_cmd,
    output logic            o_pop,
    output logic            o_valid,
    output dsdq_pkg::t_out  o_data,
    input  logic            i_stall
);

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic {
        S_IDLE,
        S_FLUSH
    } t_state;

    t_state           r_state;
    logic [CW-1:0]    r_count;
    dsdq_pkg::t_entry r_cell [CAPACITY];
    dsdq_pkg::t_entry n_cell [CAPACITY];
    logic [CAPACITY-1:0] less;
    logic             r_valid;
    dsdq_pkg::t_out   r_data;
    logic             out_free, do_insert, do_shift, emit;

    assign out_free  = !r_valid || !i_stall;
    assign do_insert = (r_state == S_IDLE) && i_cmd_valid &&
                       (i_cmd.kind == dsdq_pkg::K_PUSH) && (r_count != CW'(CAPACITY));
    assign emit      = (r_state == S_FLUSH) && out_free;
    assign do_shift  = emit;
    assign o_pop     = (r_state == S_IDLE) && i_cmd_valid;

    // Per cell: is the new key strictly below the stored one
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            less[i] = (CW'(i) < r_count) && (i_cmd.entry.key < r_cell[i].key);
        end
    end

    // Insertion chain and flush shift, each cell looks only at its neighbor
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_cell[i] = r_cell[i];
            if (do_insert) begin
                if (less[i]) begin
                    if (i > 0 && less[(i > 0) ? i - 1 : 0]) begin
                        n_cell[i] = r_cell[(i > 0) ? i - 1 : 0];
                    end else begin
                        n_cell[i] = i_cmd.entry;
                    end
                end else if (CW'(i) == r_count) begin
                    // First free cell takes the shifted tail or the new entry
                    if (i > 0 && less[(i > 0) ? i - 1 : 0]) begin
                        n_cell[i] = r_cell[(i > 0) ? i - 1 : 0];
                    end else begin
                        n_cell[i] = i_cmd.entry;
                    end
                end
            end else if (do_shift && i < CAPACITY - 1) begin
                n_cell[i] = r_cell[(i < CAPACITY - 1) ? i + 1 : i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
    end

    // Sequence commands and drive the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (r_valid && !i_stall) r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        unique case (i_cmd.kind)
                            dsdq_pkg::K_PUSH: begin
                                if (do_insert) r_count <= r_count + CW'(1);
                            end
                            dsdq_pkg::K_CLEAR: r_count <= '0;
                            dsdq_pkg::K_FLUSH: begin
                                if (r_count != '0) r_state <= S_FLUSH;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_FLUSH: begin
                    if (emit) begin
                        r_valid <= 1'b1;
                        r_count <= r_count - CW'(1);
                        if (r_count == CW'(1)) r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Hold payload of the head cell on emit
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_data <= '{out_texture_id: r_cell[0].texture_id,
                        out_pos_xy: r_cell[0].pos_xy,
                        out_size_wh: r_cell[0].size_wh,
                        out_src_rect: r_cell[0].src_rect,
                        out_rotation: r_cell[0].rotation,
                        out_color_rgba: r_cell[0].color_rgba,
                        last: (r_count == CW'(1))};
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count beyond capacity");
    a_flush_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) |-> (r_count != '0))
        else $error("flush with empty buffer");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && r_count == CW'(1)) |=> (r_state == S_IDLE && r_count == '0))
        else $error("flush did not end after last");
    a_no_pop_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) |-> !o_pop)
        else $error("command taken during flush");

endmodule

// ===== dv/depth_sorted_draw_queue_tb.sv =====
module depth_sorted_draw_queue_tb;

    localparam int IDLE_MAX   = 12;
    localparam int WDOG_LIMIT = 4000;
    localparam int N_RANDOM   = 70;
    localparam int DRAIN_WAIT = 16;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    dsdq_pkg::t_in    i_data;
    logic             o_stall;
    logic             o_valid;
    dsdq_pkg::t_out   o_data;
    logic             i_stall;

    depth_sorted_draw_queue uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

    // Clock: period 12
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predicted buffer, kept sorted the way the block keeps it
    dsdq_pkg::t_entry sorted_buf[$];
    dsdq_pkg::t_out   pending_draws[$];
    int               error_count = 0;
    int               idle_cycles = 0;

    // Apply one accepted transaction to the predicted buffer
    task automatic predict_draws(input dsdq_pkg::t_in tr);
        dsdq_pkg::t_entry e;
        int               pos;
        dsdq_pkg::t_out   r;
        case (tr.op)
            dsdq_pkg::OP_PUSH: begin
                if (sorted_buf.size() < dsdq_pkg::CAPACITY) begin
                    e.key        = tr.sort_key;
                    e.texture_id = tr.texture_id;
                    e.pos_xy     = tr.pos_xy;
                    e.size_wh    = tr.size_wh;
                    e.src_rect   = tr.src_rect;
                    e.rotation   = tr.rotation;
                    e.color_rgba = tr.color_rgba;
                    pos = sorted_buf.size();
                    // Insert after every entry whose key is not greater
                    while (pos > 0 && e.key < sorted_buf[pos-1].key) pos--;
                    sorted_buf.insert(pos, e);
                end
            end
            dsdq_pkg::OP_FLUSH: begin
                foreach (sorted_buf[i]) begin
                    r.out_texture_id = sorted_buf[i].texture_id;
                    r.out_pos_xy     = sorted_buf[i].pos_xy;
                    r.out_size_wh    = sorted_buf[i].size_wh;
                    r.out_src_rect   = sorted_buf[i].src_rect;
                    r.out_rotation   = sorted_buf[i].rotation;
                    r.out_color_rgba = sorted_buf[i].color_rgba;
                    r.last           = (i == sorted_buf.size() - 1);
                    pending_draws.push_back(r);
                end
                sorted_buf.delete();
            end
            dsdq_pkg::OP_CLEAR: sorted_buf.delete();
            default: ;
        endcase
    endtask

    // Directed table: typed expectations only on plain cases
    typedef struct {
        dsdq_pkg::t_in  tr;
        bit             has_exp;
        dsdq_pkg::t_out exp;
    } t_row;

    t_row             dir_rows[$];
    dsdq_pkg::t_out   typed_exp[$];

    function automatic dsdq_pkg::t_in mk(input logic [1:0] op, input logic [31:0] key,
                                         input logic [15:0] tex, input logic [63:0] v64,
                                         input logic [31:0] v32);
        dsdq_pkg::t_in t;
        t.op         = op;
        t.texture_id = tex;
        t.pos_xy     = v64;
        t.size_wh    = ~v64;
        t.src_rect   = {v64[31:0], v64[63:32]};
        t.sort_key   = key;
        t.rotation   = v32;
        t.color_rgba = ~v32;
        return t;
    endfunction

    function automatic dsdq_pkg::t_in rand_item(input logic [1:0] op, input int key_span);
        dsdq_pkg::t_in t;
        t.op         = op;
        t.texture_id = 16'($urandom());
        t.pos_xy     = {$urandom(), $urandom()};
        t.size_wh    = {$urandom(), $urandom()};
        t.src_rect   = {$urandom(), $urandom()};
        t.sort_key   = (key_span == 0) ? $urandom() : $urandom_range(key_span, 0) - 2;
        t.rotation   = $urandom();
        t.color_rgba = $urandom();
        return t;
    endfunction

    function automatic void add_row(input dsdq_pkg::t_in tr);
        t_row r;
        r.tr      = tr;
        r.has_exp = 1'b0;
        r.exp     = '0;
        dir_rows.push_back(r);
    endfunction

    // Drive one transaction at the falling edge, hold until accepted
    task automatic send_item(input dsdq_pkg::t_in tr);
        int gap;
        gap = $urandom_range(IDLE_MAX, 0);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= tr;
        do @(posedge i_clk); while (o_stall);
        predict_draws(tr);
        @(negedge i_clk);
    endtask

    // Receiver stall pattern: a random wait before each result
    initial begin
        int w;
        i_stall = 1'b1;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(3, 0) == 0) w = 0;
            else w = $urandom_range(IDLE_MAX, 0);
            if (w != 0) begin
                i_stall <= 1'b1;
                repeat (w) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Check each accepted result against the oldest expectation
    always @(posedge i_clk) begin
        dsdq_pkg::t_out exp;
        dsdq_pkg::t_out tex;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_draws.size() == 0) begin
                $error("unexpected result texture_id=%h", o_data.out_texture_id);
                error_count++;
            end else begin
                exp = pending_draws.pop_front();
                if (typed_exp.size() != 0) begin
                    tex = typed_exp.pop_front();
                    if (tex != exp) begin
                        $error("directed row disagrees with predictor");
                        error_count++;
                    end
                end
                if (o_data.out_texture_id !== exp.out_texture_id) begin
                    $error("out_texture_id exp %h got %h", exp.out_texture_id,
                           o_data.out_texture_id);
                    error_count++;
                end
                if (o_data.out_pos_xy !== exp.out_pos_xy) begin
                    $error("out_pos_xy exp %h got %h", exp.out_pos_xy, o_data.out_pos_xy);
                    error_count++;
                end
                if (o_data.out_size_wh !== exp.out_size_wh) begin
                    $error("out_size_wh exp %h got %h", exp.out_size_wh, o_data.out_size_wh);
                    error_count++;
                end
                if (o_data.out_src_rect !== exp.out_src_rect) begin
                    $error("out_src_rect exp %h got %h", exp.out_src_rect,
                           o_data.out_src_rect);
                    error_count++;
                end
                if (o_data.out_rotation !== exp.out_rotation) begin
                    $error("out_rotation exp %h got %h", exp.out_rotation,
                           o_data.out_rotation);
                    error_count++;
                end
                if (o_data.out_color_rgba !== exp.out_color_rgba) begin
                    $error("out_color_rgba exp %h got %h", exp.out_color_rgba,
                           o_data.out_color_rgba);
                    error_count++;
                end
                if (o_data.last !== exp.last) begin
                    $error("last exp %0b got %0b", exp.last, o_data.last);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: count cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("FAIL depth_sorted_draw_queue");
            $finish;
        end
    end

    initial begin
        dsdq_pkg::t_in  tr;
        dsdq_pkg::t_out ex;
        int             n;
        int             kspan;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data  = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: flush after reset is empty, then a single extreme entry
        add_row(mk(dsdq_pkg::OP_FLUSH, 32'h0, 16'h0, 64'h0, 32'h0));
        tr = mk(dsdq_pkg::OP_PUSH, 32'h7fff_ffff, 16'hffff, 64'hffff_ffff_ffff_ffff,
                32'h8000_0000);
        add_row(tr);
        add_row(mk(dsdq_pkg::OP_FLUSH, 32'h0, 16'h0, 64'h0, 32'h0));
        dir_rows[$].has_exp = 1'b1;
        ex.out_texture_id = 16'hffff;
        ex.out_pos_xy     = 64'hffff_ffff_ffff_ffff;
        ex.out_size_wh    = 64'h0;
        ex.out_src_rect   = 64'hffff_ffff_ffff_ffff;
        ex.out_rotation   = 32'h8000_0000;
        ex.out_color_rgba = 32'h7fff_ffff;
        ex.last           = 1'b1;
        dir_rows[$].exp   = ex;
        // Key extremes, equal keys, unused op, clear
        add_row(mk(dsdq_pkg::OP_PUSH, 32'h0000_0000, 16'h0001, 64'h0, 32'h0));
        add_row(mk(dsdq_pkg::OP_PUSH, 32'h8000_0000, 16'h0002, 64'h1234_5678_9abc_def0,
                   32'h1));
        add_row(mk(dsdq_pkg::OP_PUSH, 32'h7fff_ffff, 16'h0003, 64'h5555_aaaa_5555_aaaa,
                   32'h7fff_ffff));
        add_row(mk(dsdq_pkg::OP_PUSH, 32'h0000_0000, 16'h0004, 64'haaaa_5555_aaaa_5555,
                   32'hffff_ffff));
        add_row(mk(dsdq_pkg::OP_PUSH, 32'hffff_ffff, 16'h0005, 64'h1, 32'h2));
        add_row(mk(OP_UNUSED, 32'h0, 16'h0006, 64'h0, 32'h0));
        add_row(mk(dsdq_pkg::OP_FLUSH, 32'h0, 16'h0, 64'h0, 32'h0));
        add_row(mk(dsdq_pkg::OP_PUSH, 32'h1, 16'h0007, 64'h2, 32'h3));
        add_row(mk(dsdq_pkg::OP_CLEAR, 32'h0, 16'h0, 64'h0, 32'h0));
        add_row(mk(dsdq_pkg::OP_FLUSH, 32'h0, 16'h0, 64'h0, 32'h0));
        foreach (dir_rows[i]) begin
            if (dir_rows[i].has_exp) typed_exp.push_back(dir_rows[i].exp);
            send_item(dir_rows[i].tr);
        end

        // Fill past capacity so the full-buffer drop is hit, then flush
        for (int i = 0; i < dsdq_pkg::CAPACITY + 3; i++) begin
            send_item(rand_item(dsdq_pkg::OP_PUSH, 0));
        end
        send_item(rand_item(dsdq_pkg::OP_FLUSH, 0));

        // Random: bursts of pushes mixed with unused ops, ended by flush or clear
        n = 0;
        while (n < N_RANDOM) begin
            kspan = ($urandom_range(1, 0) == 0) ? 0 : 4;
            repeat ($urandom_range(8, 0)) begin
                send_item(rand_item(($urandom_range(15, 0) == 0) ? OP_UNUSED :
                                    dsdq_pkg::OP_PUSH, kspan));
                n++;
            end
            case ($urandom_range(5, 0))
                0: send_item(rand_item(dsdq_pkg::OP_CLEAR, 0));
                default: send_item(rand_item(dsdq_pkg::OP_FLUSH, 0));
            endcase
            n++;
        end
        send_item(rand_item(dsdq_pkg::OP_FLUSH, 0));
        i_valid <= 1'b0;

        // Drain, then allow the block's latency to pass
        while (pending_draws.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (error_count == 0 && typed_exp.size() == 0) begin
            $display("PASS depth_sorted_draw_queue");
        end else begin
            $display("FAIL depth_sorted_draw_queue");
        end
        $finish;
    end

endmodule

// ===== depth_sorted_draw_queue.f =====
rtl/dsdq_pkg.sv
rtl/dsdq_front.sv
rtl/dsdq_back.sv
rtl/depth_sorted_draw_queue.sv
dv/depth_sorted_draw_queue_tb.sv
